/* rtl/core/dpt_pkg.sv */
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared constants and types of the dive phase tracker.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned StartHoldS = 20;
  localparam logic signed [31:0] RateDescent = -32'sd500;
  localparam logic signed [31:0] RateAscent = 32'sd300;
  localparam logic [15:0] DecoMargin = 16'd300;
  localparam logic [14:0] SsLow = 15'd300;
  localparam logic [14:0] SsHigh = 15'd600;
  localparam logic [14:0] SsZoneLow = 15'd450;
  localparam logic [14:0] SsZoneHigh = 15'd550;
  localparam logic [14:0] SsTrigger = 15'd1000;

  localparam logic [2:0] PH_SURFACE = 3'd0;
  localparam logic [2:0] PH_DESCENT = 3'd1;
  localparam logic [2:0] PH_BOTTOM = 3'd2;
  localparam logic [2:0] PH_ASCENT = 3'd3;
  localparam logic [2:0] PH_DECO = 3'd4;
  localparam logic [2:0] PH_SAFETY = 3'd5;
  localparam logic [2:0] PH_INTERVAL = 3'd6;

  localparam logic [2:0] REG_FAST = 3'd0;
  localparam logic [2:0] REG_SSLEN = 3'd1;
  localparam logic [2:0] REG_START = 3'd2;
  localparam logic [2:0] REG_END = 3'd3;
  localparam logic [2:0] REG_HOLD = 3'd4;
  localparam logic [2:0] REG_AUTO = 3'd5;
  localparam logic [2:0] REG_SAFE = 3'd6;

  localparam int unsigned InWidth = 64;
  localparam int unsigned OutWidth = 104;

  typedef logic [InWidth-1:0] in_data_t;
  typedef logic [OutWidth-1:0] out_data_t;

endpackage

/* rtl/core/dive_phase_tracker.sv */
// ----------------------------------------------------------------------------
// dive_phase_tracker
// Dive start/end qualification, filtered ascent rate, alarms, safety stop.
// ----------------------------------------------------------------------------
// Flow: a surface item or a dive item with no usable time step goes straight
// to S_POST and S_OUT; a dive item that updates the rate filter first passes
// S_DIV, S_FILT and S_DIV10, with one restoring divider that takes one quotient
// bit per cycle (22 steps for the rate quotient; the /10 and /60 use reciprocal
// multiplies). Throughput: one item at a time; s_tready is low from acceptance
// until the result item is moved into the output register, so a new item is
// taken only once the last one is through.
// Reset: synchronous, active high; sets tracker state and configuration to power-on values.
module dive_phase_tracker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  dpt_pkg::in_data_t      s_tdata,  // now_seconds[31:0], depth_cm[46:32], ceiling_cm[61:47]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output dpt_pkg::out_data_t     m_tdata,  // phase, diving, dive_started, dive_ended,
                                           // ascent_alarm, ceiling_alarm, stop_required,
                                           // stop_done, climb rate[32], missed_stops[16],
                                           // surface_minutes[27], deepest_cm[15]
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import dpt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FILT = 3'd2;
  localparam logic [2:0] S_DIV10 = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  logic [13:0] fast_ascent_limit;
  logic [15:0] safety_stop_length;
  logic [14:0] start_depth, end_depth;
  logic [15:0] end_hold_seconds;
  logic auto_detect, safety_enforce;

  // tracker state
  logic        in_dive, stop_req_reg, stop_done_reg;
  logic [2:0]  phase_reg;
  logic [31:0] start_hold_since, end_hold_since, prev_time, dive_origin, record_count;
  logic [31:0] surface_start;
  logic [14:0] prev_depth, max_depth_reg;
  logic signed [31:0] rate_acc;
  logic [15:0] stop_timer, missed_count;
  logic [26:0] surface_min_reg;

  // working registers of the item in flight
  logic [2:0]  state;
  logic [31:0] now_r;
  logic [14:0] depth_r, ceil_r;
  logic        started_r, ended_r;
  logic [5:0]  cnt;
  logic [21:0] num;       // |diff*60| <= 1,966,020
  logic        neg;
  logic [31:0] dvs;
  logic [31:0] quo;
  logic [32:0] rem;
  logic signed [35:0] acc_sum;
  logic        ovalid;
  out_data_t   odata;
  out_data_t   res;

  // ---------------------------------------------------------------- APB
  logic wr;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[4:2];

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_FAST:  prdata = {18'd0, fast_ascent_limit};
      REG_SSLEN: prdata = {16'd0, safety_stop_length};
      REG_START: prdata = {17'd0, start_depth};
      REG_END:   prdata = {17'd0, end_depth};
      REG_HOLD:  prdata = {16'd0, end_hold_seconds};
      REG_AUTO:  prdata = {31'd0, auto_detect};
      REG_SAFE:  prdata = {31'd0, safety_enforce};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_ascent_limit <= 14'd1800;
      safety_stop_length <= 16'd180;
      start_depth <= 15'd120;
      end_depth <= 15'd80;
      end_hold_seconds <= 16'd60;
      auto_detect <= 1'b1;
      safety_enforce <= 1'b1;
    end else if (wr) begin
      unique case (ridx)
        REG_FAST:  fast_ascent_limit <= pwdata[13:0];
        REG_SSLEN: safety_stop_length <= pwdata[15:0];
        REG_START: start_depth <= pwdata[14:0];
        REG_END:   end_depth <= pwdata[14:0];
        REG_HOLD:  end_hold_seconds <= pwdata[15:0];
        REG_AUTO:  auto_detect <= pwdata[0];
        REG_SAFE:  safety_enforce <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = ovalid;
  assign m_tdata = odata;

  // ---------------------------------------------------------------- per-item logic
  logic [31:0] s_now;
  logic [14:0] s_depth;
  assign s_now = s_tdata[31:0];
  assign s_depth = s_tdata[46:32];

  // qualification, evaluated on the accepted item
  logic q_start, q_end;
  logic [31:0] sh_next, eh_next;
  always_comb begin
    q_start = 1'b0;
    q_end = 1'b0;
    sh_next = start_hold_since;
    eh_next = end_hold_since;
    if (auto_detect && !in_dive) begin
      if (s_depth >= start_depth) begin
        if (start_hold_since == 32'd0) sh_next = s_now;
        else if (s_now - start_hold_since >= StartHoldS) begin
          sh_next = 32'd0;
          q_start = 1'b1;
        end
      end else begin
        sh_next = 32'd0;
      end
    end else if (auto_detect && in_dive) begin
      if (s_depth <= end_depth) begin
        if (end_hold_since == 32'd0) eh_next = s_now;
        else if (s_now - end_hold_since >= {16'd0, end_hold_seconds}) begin
          eh_next = 32'd0;
          q_end = 1'b1;
        end
      end else begin
        eh_next = 32'd0;
      end
    end
  end

  // restoring divide step, one quotient bit a cycle
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh = {rem[31:0], num[21]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // /10 of the filter sum: the rate stays within +-1,966,020, so the sum
  // magnitude is below 2^25 and one reciprocal multiply is exact
  logic [24:0] acc_mag;
  logic [49:0] q10_prod;
  logic [24:0] q10;
  assign acc_mag = acc_sum[35] ? 25'(-acc_sum) : 25'(acc_sum);
  assign q10_prod = 50'(acc_mag) * 50'(25'd26843546);
  assign q10 = 25'(q10_prod[49:28]);

  // surface minutes: elapsed / 60 by reciprocal and one correction
  logic [31:0] el;
  logic [63:0] m60_prod;
  logic [26:0] m60_est, m60;
  assign el = now_r - surface_start;
  assign m60_prod = 64'(el) * 64'(32'd71582788);
  assign m60_est = m60_prod[58:32];
  assign m60 = (el - 32'(m60_est) * 32'd60 >= 32'd60) ? m60_est + 27'd1 : m60_est;

  logic [15:0] ceil_marg;
  assign ceil_marg = {1'b0, ceil_r} + DecoMargin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
      in_dive <= 1'b0; phase_reg <= PH_SURFACE;
      start_hold_since <= '0; end_hold_since <= '0;
      prev_depth <= '0; prev_time <= '0; rate_acc <= '0;
      dive_origin <= '0; record_count <= '0; max_depth_reg <= '0;
      stop_req_reg <= 1'b0; stop_done_reg <= 1'b0; stop_timer <= '0;
      missed_count <= '0; surface_start <= '0; surface_min_reg <= '0;
      started_r <= 1'b0; ended_r <= 1'b0;
    end else begin
      if (ovalid && m_tready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            now_r <= s_now;
            depth_r <= s_depth;
            ceil_r <= s_tdata[61:47];
            start_hold_since <= sh_next;
            end_hold_since <= eh_next;
            started_r <= q_start;
            ended_r <= q_end;
            if (q_start) begin
              in_dive <= 1'b1; dive_origin <= s_now; phase_reg <= PH_DESCENT;
              record_count <= '0; max_depth_reg <= '0; stop_req_reg <= 1'b0;
              stop_done_reg <= 1'b0; stop_timer <= '0;
            end else if (q_end) begin
              in_dive <= 1'b0; phase_reg <= PH_INTERVAL; surface_start <= s_now;
            end
            // set up the rate division
            neg <= s_depth > prev_depth;
            num <= (s_depth > prev_depth) ? 22'(s_depth - prev_depth) * 22'd60
                                          : 22'(prev_depth - s_depth) * 22'd60;
            dvs <= s_now - prev_time;
            rem <= '0;
            quo <= '0;
            cnt <= 6'd0;
            if (((in_dive && !q_end) || q_start) && prev_time != 32'd0 &&
                s_now != prev_time) state <= S_DIV;
            else state <= S_POST;
          end
        end
        S_DIV: begin
          if (rem_sub[32]) begin
            rem <= rem_sh;
            quo <= {quo[30:0], 1'b0};
          end else begin
            rem <= rem_sub;
            quo <= {quo[30:0], 1'b1};
          end
          num <= {num[20:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd21) state <= S_FILT;
        end
        S_FILT: begin
          // quotient fits in 21 bits; form 7*acc + 3*rate
          acc_sum <= 36'(rate_acc) * 36'sd7 +
                     (neg ? -(36'(quo[21:0]) * 36'sd3) : 36'(quo[21:0]) * 36'sd3);
          state <= S_DIV10;
        end
        S_DIV10: begin
          rate_acc <= acc_sum[35] ? -(32'(q10)) : 32'(q10);
          state <= S_POST;
        end
        S_POST: begin
          if (!in_dive) begin
            if (surface_start != 32'd0) surface_min_reg <= m60;
            res <= {4'd0, max_depth_reg, (surface_start != 32'd0) ? m60 : surface_min_reg,
                    missed_count, rate_acc, stop_done_reg, stop_req_reg, 1'b0, 1'b0,
                    ended_r, started_r, 1'b0, phase_reg};
            state <= S_OUT;
          end else begin
            logic [2:0]  ph;
            logic        req, done, calarm;
            logic [15:0] tmr, mc;
            logic [14:0] mx;
            logic [31:0] rc;
            ph = PH_BOTTOM; req = stop_req_reg; done = stop_done_reg;
            tmr = stop_timer; mc = missed_count; mx = max_depth_reg; rc = record_count;
            calarm = depth_r < ceil_r;
            if (calarm && mc != 16'hFFFF) mc = mc + 16'd1;
            if (rate_acc < RateDescent) ph = PH_DESCENT;
            else if (rate_acc > RateAscent)
              ph = (ceil_r != 15'd0 && {1'b0, depth_r} <= ceil_marg) ? PH_DECO : PH_ASCENT;
            else if (depth_r >= SsLow && depth_r <= SsHigh && stop_req_reg) ph = PH_SAFETY;
            if (safety_enforce) begin
              if (mx > SsTrigger && !done) req = 1'b1;
              if (ph == PH_SAFETY && req) begin
                if (depth_r >= SsZoneLow && depth_r <= SsZoneHigh) begin
                  if (tmr != 16'hFFFF) tmr = tmr + 16'd1;
                  if (tmr >= safety_stop_length) begin
                    done = 1'b1; req = 1'b0;
                  end
                end else begin
                  tmr = 16'd0;
                end
              end
            end
            if (now_r - dive_origin >= rc) begin
              if (depth_r > mx) mx = depth_r;
              if (rc != 32'hFFFFFFFF) rc = rc + 32'd1;
            end
            phase_reg <= ph; stop_req_reg <= req; stop_done_reg <= done;
            stop_timer <= tmr; missed_count <= mc; max_depth_reg <= mx; record_count <= rc;
            prev_depth <= depth_r; prev_time <= now_r;
            res <= {4'd0, mx, surface_min_reg, mc, rate_acc, done, req, calarm,
                    rate_acc > $signed({18'd0, fast_ascent_limit}),
                    ended_r, started_r, 1'b1, ph};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!ovalid) begin
            ovalid <= 1'b1;
            odata <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("accepted while busy");
  a_result_after_out: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state) == S_OUT) else $error("result without sequence");
  a_start_end_excl: assert property (@(posedge clk) disable iff (rst)
    !(started_r && ended_r)) else $error("start and end together");

endmodule
